FILE: src/affinity_task_queue_with_stealing_macros.svh
// Assertion macros shared by the task queue RTL.
`ifndef AFFINITY_TASK_QUEUE_WITH_STEALING_MACROS_SVH
`define AFFINITY_TASK_QUEUE_WITH_STEALING_MACROS_SVH

`ifndef SYNTH
`define ATQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ATQ_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define ATQ_ASSERT(lbl, prop, msg)
`define ATQ_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: src/atq_pkg.sv
// Shared types and constants for the affinity task queue.
package atq_pkg;

    localparam int NUM_QUEUES_DEF  = 4;
    localparam int SLOTS_DEF       = 2048;
    localparam int HANDLE_BITS_DEF = 32;

    // slot flags are kept a row of ROW_BITS slots per memory word
    localparam int ROW_BITS = 32;
    localparam int ROW_LOG  = 5;
    localparam int CFG_BITS = 12;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_PUSH,
        MODE_AFFINE,
        MODE_STEAL
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_CHECK,
        ST_TAKE,
        ST_FETCH,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic               hit;
        logic [ROW_LOG-1:0] bit_idx;
    } find_t;

endpackage

FILE: src/atq_find.sv
// First matching slot within one flag row, limited to the active scan window.
module atq_find
    import atq_pkg::*;
#(
    parameter int POS_W = 11,
    parameter int ROW_W = 6,
    parameter int CNT_W = 12
) (
    input  logic [ROW_BITS-1:0] cand,
    input  logic [ROW_W-1:0]    row,
    input  logic [POS_W-1:0]    start,
    input  logic [CNT_W-1:0]    limit,
    input  logic                wrap_phase,
    output find_t               res
);

    localparam int EW = ROW_W + ROW_LOG + 1;

    logic [ROW_BITS-1:0] elig;
    logic [EW-1:0]       pos_ext [ROW_BITS];

    always_comb begin
        for (int b = 0; b < ROW_BITS; b++) begin
            pos_ext[b] = EW'({row, ROW_LOG'(b)});
            elig[b] = cand[b] && (pos_ext[b] < EW'(limit)) &&
                      (wrap_phase ? (pos_ext[b] < EW'(start))
                                  : (pos_ext[b] >= EW'(start)));
        end
    end

    // lowest eligible slot wins
    always_comb begin
        res.hit     = |elig;
        res.bit_idx = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (elig[b]) begin
                res.bit_idx = ROW_LOG'(b);
            end
        end
    end

endmodule

FILE: src/affinity_task_queue_with_stealing.sv
// Affinity task queue with work stealing: top level with flag and handle memories.
// A push steps through START, a READ and CHECK per flag row read, TAKE and RESP; a pop also
// runs FETCH, and a steal revisits START for the empty own queue and once per queue skipped.
// R: flag rows read, 32 slots a row. Throughput: one item at a time; R is at most
// ceil(slots/32)+1 per queue scanned, set by the single-port flag memory walk.
// Reset and slots_in_use writes clear all NUM_QUEUES*ceil(SLOTS/32) flag rows (256), no transfer.
`include "affinity_task_queue_with_stealing_macros.svh"

module affinity_task_queue_with_stealing
    import atq_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [1:0]          s_queue_id,
    input  logic                s_bound_to_queue,
    input  logic [31:0]         s_task_handle,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [10:0]         m_prior_count,
    output logic [31:0]         m_popped_handle,
    output logic [1:0]          m_source_queue,
    output logic                m_was_stolen
);

    // geometry
    localparam int RPQ    = (SLOTS + ROW_BITS - 1) / ROW_BITS;   // flag rows per queue
    localparam int ROW_W  = (RPQ > 1) ? $clog2(RPQ) : 1;
    localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int POS_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int FROWS  = NUM_QUEUES * RPQ;
    localparam int FAW    = (FROWS > 1) ? $clog2(FROWS) : 1;
    localparam int HDEPTH = NUM_QUEUES * SLOTS;
    localparam int HAW    = $clog2(HDEPTH);

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    mode_t  mode_reg;

    logic [CNT_W-1:0] siu_reg;                 // active capacity per queue
    logic [FAW-1:0]   clr_row_reg;
    logic [QW-1:0]    cur_q_reg;

    logic [CNT_W-1:0] cnt_reg      [NUM_QUEUES];
    logic [CNT_W-1:0] unb_reg      [NUM_QUEUES];
    logic [POS_W-1:0] push_ptr_reg [NUM_QUEUES];
    logic [POS_W-1:0] pop_ptr_reg  [NUM_QUEUES];

    // per-item working registers
    logic                  bound_reg;
    logic [HANDLE_BITS-1:0] handle_in_reg;
    logic [POS_W-1:0]      start_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_LOG-1:0]    bit_reg;
    logic                  phase_reg;       // 0: slots at/after start, 1: wrapped part
    logic [2*ROW_BITS-1:0] row_data_reg;

    // pending result
    status_t     res_status_reg;
    logic [10:0] res_prior_reg;
    logic [31:0] res_handle_reg;
    logic [1:0]  res_source_reg;
    logic        res_stolen_reg;

    // output register
    logic        m_valid_reg;
    status_t     m_status_reg;
    logic [10:0] m_prior_reg;
    logic [31:0] m_handle_reg;
    logic [1:0]  m_source_reg;
    logic        m_stolen_reg;

    // ------------------------------------------------------------------
    // memories: flag rows {unbound bits, valid bits} and task handles
    // ------------------------------------------------------------------
    logic [2*ROW_BITS-1:0]  flag_mem [FROWS];
    logic [2*ROW_BITS-1:0]  flag_rd;
    logic [2*ROW_BITS-1:0]  flag_wdata;
    logic [FAW-1:0]         flag_addr;
    logic                   flag_re, flag_we;

    logic [HANDLE_BITS-1:0] handle_mem [HDEPTH];
    logic [HANDLE_BITS-1:0] handle_rd;
    logic [HAW-1:0]         handle_addr;
    logic                   handle_re, handle_we;

    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[flag_addr] <= flag_wdata;
        end
        if (flag_re) begin
            flag_rd <= flag_mem[flag_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (handle_we) begin
            handle_mem[handle_addr] <= handle_in_reg;
        end
        if (handle_re) begin
            handle_rd <= handle_mem[handle_addr];
        end
    end

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [4:0]       q_tmp;
    logic [QW-1:0]    q_in;
    logic [CNT_W-1:0] cnt_cur, unb_cur;
    logic [POS_W-1:0] ptr_sel, start_clip, pos_next_slot;
    logic             q_last, q_full, steal_skip;
    logic [ROW_W-1:0] row_last;
    logic             row_end;
    logic [ROW_BITS-1:0] valid_bits, unb_bits, cand;
    find_t            find_res;
    logic [POS_W-1:0] hit_pos;
    logic [CFG_BITS:0] cfg_ext, cfg_clip;
    logic             pop_take;

    // queue_id modulo NUM_QUEUES by repeated subtract (value below 4)
    always_comb begin
        q_tmp = 5'(s_queue_id);
        for (int i = 0; i < 3; i++) begin
            if (q_tmp >= 5'(NUM_QUEUES)) begin
                q_tmp = q_tmp - 5'(NUM_QUEUES);
            end
        end
        q_in = QW'(q_tmp);
    end

    assign cnt_cur    = cnt_reg[cur_q_reg];
    assign unb_cur    = unb_reg[cur_q_reg];
    assign ptr_sel    = (mode_reg == MODE_PUSH) ? push_ptr_reg[cur_q_reg]
                                                : pop_ptr_reg[cur_q_reg];
    assign start_clip = (CNT_W'(ptr_sel) >= siu_reg) ? '0 : ptr_sel;
    assign q_last     = (cur_q_reg == QW'(NUM_QUEUES - 1));
    assign q_full     = (cnt_cur >= siu_reg);
    assign steal_skip = (cnt_cur == '0) || (unb_cur == '0);
    assign pop_take   = (state_reg == ST_TAKE) && (mode_reg != MODE_PUSH);

    assign pos_next_slot = (CNT_W'(pos_reg) + CNT_W'(1) >= siu_reg) ? '0
                                                                    : pos_reg + POS_W'(1);

    // last row of the current scan window
    assign row_last = phase_reg ? ROW_W'(start_reg >> ROW_LOG)
                                : ROW_W'((siu_reg - CNT_W'(1)) >> ROW_LOG);
    assign row_end  = (row_reg == row_last);

    assign valid_bits = flag_rd[ROW_BITS-1:0];
    assign unb_bits   = flag_rd[2*ROW_BITS-1:ROW_BITS];

    always_comb begin
        unique case (mode_reg)
            MODE_PUSH:   cand = ~valid_bits;
            MODE_AFFINE: cand = valid_bits;
            MODE_STEAL:  cand = valid_bits & unb_bits;
            default:     cand = '0;
        endcase
    end

    atq_find #(
        .POS_W (POS_W),
        .ROW_W (ROW_W),
        .CNT_W (CNT_W)
    ) u_find (
        .cand       (cand),
        .row        (row_reg),
        .start      (start_reg),
        .limit      (siu_reg),
        .wrap_phase (phase_reg),
        .res        (find_res)
    );

    assign hit_pos = POS_W'({row_reg, find_res.bit_idx});

    // capacity write: zero counts as one, clip to SLOTS
    always_comb begin
        cfg_ext  = (CFG_BITS + 1)'(cfg_wr_data);
        cfg_clip = cfg_ext;
        if (cfg_ext == '0) begin
            cfg_clip = (CFG_BITS + 1)'(1);
        end else if (cfg_ext > (CFG_BITS + 1)'(SLOTS)) begin
            cfg_clip = (CFG_BITS + 1)'(SLOTS);
        end
    end

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_row_reg == FAW'(FROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                unique case (mode_reg)
                    MODE_PUSH:   state_next = q_full ? ST_RESP : ST_READ;
                    MODE_AFFINE: state_next = (cnt_cur != '0) ? ST_READ : ST_START;
                    MODE_STEAL: begin
                        if (!steal_skip) begin
                            state_next = ST_READ;
                        end else if (q_last) begin
                            state_next = ST_RESP;
                        end
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_READ: state_next = ST_CHECK;
            ST_CHECK: begin
                if (find_res.hit) begin
                    state_next = ST_TAKE;
                end else if (!row_end || !phase_reg) begin
                    state_next = ST_READ;
                end else if (mode_reg == MODE_PUSH) begin
                    state_next = ST_RESP;
                end else if (mode_reg == MODE_STEAL && q_last) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_START;
                end
            end
            ST_TAKE:  state_next = (mode_reg == MODE_PUSH) ? ST_RESP : ST_FETCH;
            ST_FETCH: state_next = ST_RESP;
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
        if (cfg_wr_en) begin
            state_next = ST_CLEAR;
        end
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready    = 1'b0;
        flag_re    = 1'b0;
        flag_we    = 1'b0;
        flag_wdata = row_data_reg;
        flag_addr  = FAW'(cur_q_reg) * FAW'(RPQ) + FAW'(row_reg);
        handle_re  = 1'b0;
        handle_we  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                flag_we    = 1'b1;
                flag_wdata = '0;
                flag_addr  = clr_row_reg;
            end
            ST_IDLE: s_ready = 1'b1;
            ST_READ: flag_re = 1'b1;
            ST_TAKE: begin
                flag_we = 1'b1;
                if (mode_reg == MODE_PUSH) begin
                    flag_wdata[bit_reg]            = 1'b1;
                    flag_wdata[ROW_BITS + bit_reg] = !bound_reg;
                    handle_we                      = 1'b1;
                end else begin
                    flag_wdata[bit_reg] = 1'b0;
                    handle_re           = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign handle_addr = HAW'(cur_q_reg) * HAW'(SLOTS) + HAW'(pos_reg);

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            siu_reg     <= CNT_W'(SLOTS);
            clr_row_reg <= '0;
            cur_q_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                cnt_reg[i]      <= '0;
                unb_reg[i]      <= '0;
                push_ptr_reg[i] <= '0;
                pop_ptr_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;

            // result register: load on leaving RESP, else drop after its transfer
            if (state_reg == ST_RESP && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // queue selection
            if (state_reg == ST_IDLE && s_valid) begin
                cur_q_reg <= q_in;
            end else if (state_reg == ST_START) begin
                if (mode_reg == MODE_AFFINE && cnt_cur == '0) begin
                    cur_q_reg <= '0;
                end else if (mode_reg == MODE_STEAL && steal_skip && !q_last) begin
                    cur_q_reg <= cur_q_reg + QW'(1);
                end
            end else if (state_reg == ST_CHECK && !find_res.hit && row_end && phase_reg) begin
                if (mode_reg == MODE_AFFINE) begin
                    cur_q_reg <= '0;
                end else if (mode_reg == MODE_STEAL && !q_last) begin
                    cur_q_reg <= cur_q_reg + QW'(1);
                end
            end

            if (cfg_wr_en) begin
                // capacity write empties every queue
                siu_reg     <= CNT_W'(cfg_clip);
                clr_row_reg <= '0;
                for (int i = 0; i < NUM_QUEUES; i++) begin
                    cnt_reg[i]      <= '0;
                    unb_reg[i]      <= '0;
                    push_ptr_reg[i] <= '0;
                    pop_ptr_reg[i]  <= '0;
                end
            end else begin
                if (state_reg == ST_CLEAR) begin
                    clr_row_reg <= clr_row_reg + FAW'(1);
                end

                // counter and pointer updates when a slot is filled or emptied
                if (state_reg == ST_TAKE) begin
                    if (mode_reg == MODE_PUSH) begin
                        cnt_reg[cur_q_reg]      <= cnt_cur + CNT_W'(1);
                        push_ptr_reg[cur_q_reg] <= pos_next_slot;
                        if (!bound_reg) begin
                            unb_reg[cur_q_reg] <= unb_cur + CNT_W'(1);
                        end
                    end else begin
                        if (row_data_reg[ROW_BITS + bit_reg] && unb_cur != '0) begin
                            unb_reg[cur_q_reg] <= unb_cur - CNT_W'(1);
                        end
                        if (cnt_cur != '0) begin
                            cnt_reg[cur_q_reg] <= cnt_cur - CNT_W'(1);
                        end
                        if (cnt_cur <= CNT_W'(1)) begin
                            // queue drained: both pointers back to slot 0
                            push_ptr_reg[cur_q_reg] <= '0;
                            pop_ptr_reg[cur_q_reg]  <= '0;
                        end else if (mode_reg == MODE_AFFINE) begin
                            pop_ptr_reg[cur_q_reg] <= pos_reg;
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                bound_reg     <= s_bound_to_queue;
                handle_in_reg <= HANDLE_BITS'(s_task_handle);
                mode_reg      <= (cmd_t'(s_cmd) == CMD_PUSH) ? MODE_PUSH : MODE_AFFINE;
            end
            ST_START: begin
                start_reg <= start_clip;
                row_reg   <= ROW_W'(start_clip >> ROW_LOG);
                phase_reg <= 1'b0;
                if (mode_reg == MODE_PUSH && q_full) begin
                    res_status_reg <= STATUS_FULL;
                    res_prior_reg  <= '0;
                    res_handle_reg <= '0;
                    res_source_reg <= '0;
                    res_stolen_reg <= 1'b0;
                end else if (mode_reg == MODE_AFFINE && cnt_cur == '0) begin
                    mode_reg <= MODE_STEAL;
                end else if (mode_reg == MODE_STEAL && steal_skip && q_last) begin
                    res_status_reg <= STATUS_EMPTY;
                    res_prior_reg  <= '0;
                    res_handle_reg <= '0;
                    res_source_reg <= '0;
                    res_stolen_reg <= 1'b0;
                end
            end
            ST_CHECK: begin
                if (find_res.hit) begin
                    pos_reg      <= hit_pos;
                    bit_reg      <= find_res.bit_idx;
                    row_data_reg <= flag_rd;
                end else if (!row_end) begin
                    row_reg <= row_reg + ROW_W'(1);
                end else if (!phase_reg) begin
                    phase_reg <= 1'b1;
                    row_reg   <= '0;
                end else if (mode_reg == MODE_AFFINE) begin
                    mode_reg <= MODE_STEAL;
                end else if (mode_reg == MODE_PUSH || q_last) begin
                    res_status_reg <= (mode_reg == MODE_PUSH) ? STATUS_FULL : STATUS_EMPTY;
                    res_prior_reg  <= '0;
                    res_handle_reg <= '0;
                    res_source_reg <= '0;
                    res_stolen_reg <= 1'b0;
                end
            end
            ST_TAKE: begin
                if (mode_reg == MODE_PUSH) begin
                    res_status_reg <= STATUS_OK;
                    res_prior_reg  <= 11'(cnt_cur);
                    res_handle_reg <= '0;
                    res_source_reg <= '0;
                    res_stolen_reg <= 1'b0;
                end
            end
            ST_FETCH: begin
                res_status_reg <= STATUS_OK;
                res_prior_reg  <= '0;
                res_handle_reg <= 32'(handle_rd);
                res_source_reg <= 2'(cur_q_reg);
                res_stolen_reg <= (mode_reg == MODE_STEAL);
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_status_reg <= res_status_reg;
                    m_prior_reg  <= res_prior_reg;
                    m_handle_reg <= res_handle_reg;
                    m_source_reg <= res_source_reg;
                    m_stolen_reg <= res_stolen_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_prior_count   = m_prior_reg;
    assign m_popped_handle = m_handle_reg;
    assign m_source_queue  = m_source_reg;
    assign m_was_stolen    = m_stolen_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ATQ_ASSERT(a_cnt_cap, (cnt_reg[cur_q_reg] <= siu_reg), "queue count above capacity")
    `ATQ_ASSERT(a_unb_cnt, (unb_reg[cur_q_reg] <= cnt_reg[cur_q_reg]), "unbound above count")
    `ATQ_ASSERT(a_stolen_ok, m_valid_reg && m_stolen_reg |-> m_status_reg == STATUS_OK, "steal flag")
    `ATQ_ASSERT_NEVER(a_take_empty, pop_take && cnt_cur == '0, "pop took from an empty queue")

endmodule

FILE: tb/affinity_task_queue_with_stealing_tb.sv
// Testbench for the affinity task queue: random push/pop traffic checked against a predictor.
module affinity_task_queue_with_stealing_tb;
    import atq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ          = NUM_QUEUES_DEF;
    localparam int DEPTH       = SLOTS_DEF;
    localparam int STALL_LIMIT = 20000;   // idle cycles before the watchdog trips
    localparam int DRAIN_WAIT  = 1200;    // worst scan latency with margin

    // one request as the sender presents it
    typedef struct {
        cmd_t        cmd;
        logic [1:0]  qid;
        logic        bound;
        logic [31:0] handle;
        bit          drain;     // sender waits for all results before offering this one
    } task_req_t;

    // one response as the block should return it
    typedef struct {
        status_t     status;
        logic [10:0] prior;
        logic [31:0] handle;
        logic [1:0]  src;
        logic        stolen;
    } task_rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [11:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = 1'b0;
    logic [1:0]  s_queue_id = '0;
    logic        s_bound_to_queue = 1'b0;
    logic [31:0] s_task_handle = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [10:0] m_prior_count;
    logic [31:0] m_popped_handle;
    logic [1:0]  m_source_queue;
    logic        m_was_stolen;

    always #5 aclk = ~aclk;

    affinity_task_queue_with_stealing dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_queue_id       (s_queue_id),
        .s_bound_to_queue (s_bound_to_queue),
        .s_task_handle    (s_task_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_prior_count    (m_prior_count),
        .m_popped_handle  (m_popped_handle),
        .m_source_queue   (m_source_queue),
        .m_was_stolen     (m_was_stolen)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the slot tables and per-queue bookkeeping.
    // ---------------------------------------------------------------
    logic [31:0] sh_handle [NQ][DEPTH];
    bit          sh_valid  [NQ][DEPTH];
    bit          sh_bound  [NQ][DEPTH];
    int          sh_count   [NQ];
    int          sh_unbound [NQ];
    int          sh_push_ptr[NQ];
    int          sh_pop_ptr [NQ];
    int          capacity = DEPTH;

    task_req_t pending_reqs[$];
    task_rsp_t expected_rsps[$];

    int  n_push, n_pop, n_full, n_none, n_stolen, n_rsp;
    bit  any_error = 1'b0;
    bit  in_taken = 1'b0;    // sender's item went across at the last rising edge
    int  send_gap = 0;
    int  recv_gap = 0;
    int  long_hold = 0;
    bit  long_hold_done = 1'b0;
    int  idle_cycles = 0;

    function automatic void empty_all_queues();
        for (int q = 0; q < NQ; q++) begin
            for (int s = 0; s < DEPTH; s++) sh_valid[q][s] = 1'b0;
            sh_count[q] = 0;
            sh_unbound[q] = 0;
            sh_push_ptr[q] = 0;
            sh_pop_ptr[q] = 0;
        end
    endfunction

    function automatic void set_capacity(logic [11:0] v);
        int c;
        c = v;
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        capacity = c;
        empty_all_queues();
    endfunction

    function automatic int wrap_slot(int p);
        return (p + 1 >= capacity) ? 0 : p + 1;
    endfunction

    // removes one task and keeps counts and pointers in step
    function automatic logic [31:0] remove_task(int q, int p);
        sh_valid[q][p] = 1'b0;
        if (!sh_bound[q][p] && sh_unbound[q] > 0) sh_unbound[q]--;
        if (sh_count[q] > 0) sh_count[q]--;
        if (sh_count[q] == 0) begin
            sh_push_ptr[q] = 0;
            sh_pop_ptr[q] = 0;
        end
        return sh_handle[q][p];
    endfunction

    function automatic task_rsp_t dispatch_task(task_req_t r);
        task_rsp_t o;
        int q, p, i;
        o = '{STATUS_OK, '0, '0, '0, 1'b0};
        q = r.qid % NQ;
        if (r.cmd == CMD_PUSH) begin
            if (sh_count[q] >= capacity) begin
                o.status = STATUS_FULL;
                return o;
            end
            p = sh_push_ptr[q];
            if (p >= capacity) p = 0;
            for (i = 0; i < capacity; i++) begin
                if (!sh_valid[q][p]) break;
                p = wrap_slot(p);
            end
            if (i == capacity) begin
                o.status = STATUS_FULL;
                return o;
            end
            sh_handle[q][p] = r.handle;
            sh_bound[q][p] = r.bound;
            sh_valid[q][p] = 1'b1;
            sh_push_ptr[q] = wrap_slot(p);
            o.prior = 11'(sh_count[q]);
            sh_count[q]++;
            if (!r.bound) sh_unbound[q]++;
            return o;
        end
        // own queue first
        if (sh_count[q] > 0) begin
            p = sh_pop_ptr[q];
            if (p >= capacity) p = 0;
            for (i = 0; i < capacity; i++) begin
                if (sh_valid[q][p]) begin
                    sh_pop_ptr[q] = p;
                    o.handle = remove_task(q, p);
                    o.src = 2'(q);
                    return o;
                end
                p = wrap_slot(p);
            end
        end
        // steal: lowest queue holding an unbound task
        for (int k = 0; k < NQ; k++) begin
            if (sh_count[k] == 0 || sh_unbound[k] == 0) continue;
            p = sh_pop_ptr[k];
            if (p >= capacity) p = 0;
            for (i = 0; i < capacity; i++) begin
                if (sh_valid[k][p] && !sh_bound[k][p]) begin
                    o.handle = remove_task(k, p);
                    o.src = 2'(k);
                    o.stolen = 1'b1;
                    return o;
                end
                p = wrap_slot(p);
            end
        end
        o.status = STATUS_EMPTY;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic add_req(cmd_t c, int q, bit b, logic [31:0] h, bit d = 1'b0);
        task_req_t r;
        r.cmd = c;
        r.qid = 2'(q);
        r.bound = b;
        r.handle = h;
        r.drain = d;
        pending_reqs = {pending_reqs, r};
    endtask

    // push_pct sets the push/pop mix; a narrow queue set concentrates traffic
    task automatic add_random(int n, int push_pct, int q_hi);
        for (int i = 0; i < n; i++) begin
            add_req(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP,
                    int'($urandom_range(q_hi)), 1'($urandom_range(1)), $urandom(),
                    $urandom_range(99) == 0);
        end
    endtask

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !s_valid && expected_rsps.size() == 0);
        repeat (20) @(negedge aclk);
    endtask

    // register write is only done with the block quiet
    task automatic write_capacity(logic [11:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        set_capacity(v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sender: presents requests at the falling edge, random gaps.
    // Mostly no gap, sometimes a short one, occasionally a long one.
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && expected_rsps.size() > 0)) begin
                s_valid <= 1'b1;
                s_cmd <= pending_reqs[0].cmd;
                s_queue_id <= pending_reqs[0].qid;
                s_bound_to_queue <= pending_reqs[0].bound;
                s_task_handle <= pending_reqs[0].handle;
                void'(pending_reqs.pop_front());
                case ($urandom_range(19))
                    0: send_gap <= $urandom_range(60, 20);
                    1, 2, 3, 4: send_gap <= $urandom_range(3, 1);
                    default: send_gap <= 0;
                endcase
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random backpressure, plus one long hold after some
    // traffic so the block backs up against the sender.
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_ready <= 1'b0;
        end else if (!long_hold_done && n_rsp >= 150) begin
            long_hold_done <= 1'b1;
            long_hold <= 400;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            case ($urandom_range(19))
                0: recv_gap <= $urandom_range(50, 15);
                1, 2, 3: recv_gap <= $urandom_range(3, 1);
                default: recv_gap <= 0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check result transfers, predict on request transfers.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        task_rsp_t e;
        task_req_t r;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            n_rsp <= n_rsp + 1;
            if (expected_rsps.size() == 0) begin
                $error("result transfer with nothing expected");
                any_error = 1'b1;
            end else begin
                e = expected_rsps.pop_front();
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    any_error = 1'b1;
                end
                if (m_prior_count !== e.prior) begin
                    $error("prior_count: expected %0d, got %0d", e.prior, m_prior_count);
                    any_error = 1'b1;
                end
                if (m_popped_handle !== e.handle) begin
                    $error("popped_handle: expected %h, got %h", e.handle, m_popped_handle);
                    any_error = 1'b1;
                end
                if (m_source_queue !== e.src) begin
                    $error("source_queue: expected %0d, got %0d", e.src, m_source_queue);
                    any_error = 1'b1;
                end
                if (m_was_stolen !== e.stolen) begin
                    $error("was_stolen: expected %0d, got %0d", e.stolen, m_was_stolen);
                    any_error = 1'b1;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            r.cmd = cmd_t'(s_cmd);
            r.qid = s_queue_id;
            r.bound = s_bound_to_queue;
            r.handle = s_task_handle;
            r.drain = 1'b0;
            e = dispatch_task(r);
            expected_rsps = {expected_rsps, e};
            if (r.cmd == CMD_PUSH) n_push++;
            else n_pop++;
            if (e.status == STATUS_FULL) n_full++;
            if (e.status == STATUS_EMPTY) n_none++;
            if (e.stolen) n_stolen++;
        end
    end

    // watchdog: too long without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        empty_all_queues();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty pop, extreme handles, own pop, steal, bound tasks kept
        add_req(CMD_POP, 0, 1'b0, 32'h0);
        add_req(CMD_PUSH, 0, 1'b1, 32'hFFFF_FFFF);
        add_req(CMD_PUSH, 0, 1'b0, 32'h0000_0000);
        add_req(CMD_PUSH, 3, 1'b1, 32'hA5A5_5A5A);
        add_req(CMD_PUSH, 2, 1'b0, 32'h5A5A_A5A5);
        add_req(CMD_POP, 1, 1'b0, 32'h0);       // steals unbound from queue 0
        add_req(CMD_POP, 1, 1'b1, 32'h0);       // steals from queue 2
        add_req(CMD_POP, 1, 1'b0, 32'h0);       // only bound left: nothing
        add_req(CMD_POP, 3, 1'b0, 32'h0);       // own bound task
        add_req(CMD_PUSH, 1, 1'b0, 32'h1234_5678);
        add_req(CMD_POP, 1, 1'b0, 32'h0);       // own pop of an unbound task
        add_req(CMD_POP, 2, 1'b0, 32'h0);       // must not see it again
        add_req(CMD_POP, 0, 1'b0, 32'h0);
        add_req(CMD_POP, 0, 1'b0, 32'h0);
        add_random(230, 55, 3);

        // capacity 0 clips to one slot: full on the second push
        write_capacity(12'd0);
        add_req(CMD_PUSH, 2, 1'b0, 32'hDEAD_BEEF, 1'b1);
        add_req(CMD_PUSH, 2, 1'b1, 32'hCAFE_F00D);
        add_req(CMD_POP, 2, 1'b0, 32'h0);
        add_random(120, 60, 3);

        // three slots: pointer wrap with holes left by steals
        write_capacity(12'd3);
        add_random(200, 60, 3);

        // above the memory depth clips to the full size
        write_capacity(12'd4095);
        add_random(150, 75, 1);

        // mid-size capacity, push-heavy to reach full
        write_capacity(12'd37);
        add_random(180, 80, 1);
        add_random(100, 30, 3);

        write_capacity(12'd2048);
        add_random(40, 50, 3);

        wait_idle();
        repeat (DRAIN_WAIT / 20) @(negedge aclk);
        $display("Covered %0d pushes (%0d full) and %0d pops (%0d stolen, %0d empty)",
                 n_push, n_full, n_pop, n_stolen, n_none);
        $display("over capacities 1, 3, 37 and 2048 with random backpressure on both sides");
        if (!any_error && expected_rsps.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
